[rtl/kmp_pkg.sv]
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants and types for the streaming substring matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int MAX_PATTERN_LENGTH = 32;
  localparam int POSITION_WIDTH     = 32;
  localparam int LEN_W              = 6;
  localparam int MATCH_START_W      = 32;
  localparam int CFG_DATA_W         = 64;
  localparam int CFG_ADDR_W         = 6;
  localparam int REG_IDX_W          = 3;
  localparam int PAT_WORD_W         = 64;
  localparam int PAT_BITS           = 8 * MAX_PATTERN_LENGTH;
  localparam int PAT_IDX_W          = (MAX_PATTERN_LENGTH > 1) ?
                                      $clog2(MAX_PATTERN_LENGTH) : 1;

  // Register indexes; the byte address is eight times the index.
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_3 = 3'd4;

  // Configuration as seen by the matcher core.
  typedef struct packed {
    logic [LEN_W-1:0]    eff_len;  // clamped to 1..MAX_PATTERN_LENGTH
    logic [PAT_BITS-1:0] pattern;  // byte k at bits 8k upward
    logic                wr;       // a register write completes this cycle
  } kmp_cfg_t;

  // Control common to every cell of the chain.
  typedef struct packed {
    logic accept;  // a text word is taken this cycle
    logic clear;   // drop every partial match
  } kmp_cell_ctrl_t;

endpackage

[rtl/kmp_if.sv]
// ----------------------------------------------------------------------------
// kmp_in_if / kmp_out_if
// Valid/ready channels for text words and match result words.
// ----------------------------------------------------------------------------
interface kmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       new_text;

  modport source (output valid, output text_char, output new_text, input ready);
  modport sink   (input valid, input text_char, input new_text, output ready);
endinterface

interface kmp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             match_found;
  logic [kmp_pkg::MATCH_START_W-1:0] match_start;
  logic                             position_saturated;

  modport source (output valid, output match_found, output match_start,
                  output position_saturated, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input position_saturated, output ready);
endinterface

[rtl/kmp_cell.sv]
// ----------------------------------------------------------------------------
// kmp_cell
// One comparator cell: remembers whether the pattern prefix ending at its
// byte matched the text ending at the previous word.
// ----------------------------------------------------------------------------
module kmp_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kmp_pkg::kmp_cell_ctrl_t ctrl,
  input  logic [7:0]              text_char,
  input  logic [7:0]              pat_byte,
  input  logic                    link_in,   // prefix one shorter matched
  output logic                    hit_nxt,   // prefix through this byte matches now
  output logic                    hit_r
);

  assign hit_nxt = link_in && (text_char == pat_byte);

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      hit_r <= 1'b0;
    end else if (ctrl.accept) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

[rtl/kmp_regs.sv]
// ----------------------------------------------------------------------------
// kmp_regs
// APB-style register file holding the pattern length and pattern bytes.
// ----------------------------------------------------------------------------
module kmp_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [kmp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [kmp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output kmp_pkg::kmp_cfg_t              cfg
);

  logic [kmp_pkg::LEN_W-1:0]      len_r;
  logic [kmp_pkg::PAT_WORD_W-1:0] word0_r, word1_r, word2_r, word3_r;
  logic [kmp_pkg::REG_IDX_W-1:0]  idx;
  logic                           wr_en;
  logic                           idx_mapped;
  logic [kmp_pkg::LEN_W-1:0]      eff_len;
  logic [4*kmp_pkg::PAT_WORD_W-1:0] all_words;

  assign cfg_pready = 1'b1;
  assign idx   = cfg_paddr[kmp_pkg::CFG_ADDR_W-1:3];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Writes to addresses outside the map change nothing at all.
  assign idx_mapped = idx inside {[kmp_pkg::REG_PATTERN_LENGTH:kmp_pkg::REG_PATTERN_BYTES_3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= kmp_pkg::LEN_W'(1);
      word0_r <= '0;
      word1_r <= '0;
      word2_r <= '0;
      word3_r <= '0;
    end else if (wr_en) begin
      case (idx)
        kmp_pkg::REG_PATTERN_LENGTH:  len_r   <= cfg_pwdata[kmp_pkg::LEN_W-1:0];
        kmp_pkg::REG_PATTERN_BYTES_0: word0_r <= cfg_pwdata;
        kmp_pkg::REG_PATTERN_BYTES_1: word1_r <= cfg_pwdata;
        kmp_pkg::REG_PATTERN_BYTES_2: word2_r <= cfg_pwdata;
        kmp_pkg::REG_PATTERN_BYTES_3: word3_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kmp_pkg::REG_PATTERN_LENGTH:
        cfg_prdata = kmp_pkg::CFG_DATA_W'(len_r);
      kmp_pkg::REG_PATTERN_BYTES_0: cfg_prdata = word0_r;
      kmp_pkg::REG_PATTERN_BYTES_1: cfg_prdata = word1_r;
      kmp_pkg::REG_PATTERN_BYTES_2: cfg_prdata = word2_r;
      kmp_pkg::REG_PATTERN_BYTES_3: cfg_prdata = word3_r;
      default:                      cfg_prdata = '0;
    endcase
  end

  // A length of zero behaves as one; anything past the cell count is clamped.
  always_comb begin
    if (len_r == '0) begin
      eff_len = kmp_pkg::LEN_W'(1);
    end else if (len_r > kmp_pkg::LEN_W'(kmp_pkg::MAX_PATTERN_LENGTH)) begin
      eff_len = kmp_pkg::LEN_W'(kmp_pkg::MAX_PATTERN_LENGTH);
    end else begin
      eff_len = len_r;
    end
  end

  assign all_words = {word3_r, word2_r, word1_r, word0_r};
  assign cfg       = '{eff_len: eff_len,
                       pattern: all_words[kmp_pkg::PAT_BITS-1:0],
                       wr:      wr_en && idx_mapped};

endmodule

[rtl/kmp_substring_matcher.sv]
// ----------------------------------------------------------------------------
// kmp_substring_matcher
// Streaming substring matcher reporting every (overlapping) occurrence.
// ----------------------------------------------------------------------------
// Text enters one byte per word on in_ch; a set new_text bit marks the first
// byte of a new text and restarts the position count at zero. Each text word
// produces exactly one result word on out_ch, holding the match flag, the
// zero-based start of the occurrence ending at that byte (zero when there is
// none) and a sticky flag set once the position counter hits its maximum.
// The pattern, 1 to 32 bytes, is written over the APB-style cfg_ port, one
// register every 8 bytes of address; every write to one of these registers
// drops all partial matches. Configuration is expected only while no word is
// in flight.
// A row of comparator cells, one per pattern byte, does the search: cell k
// remembers whether pattern bytes 0..k matched the text ending at the last
// byte, and passes that bit to cell k+1 as each word arrives. The result is
// known in the cycle the word is taken and is held in an output register, so
// a result appears in the cycle after its word is accepted and the block takes
// one word per cycle while the receiver keeps up. When out_ch stalls the
// result register holds and in_ch.ready drops until it is drained.
// Reset (rst_n low at a clock edge) restores length one, an all-zero
// pattern, position zero and an empty output register; no clearing pass.
// ----------------------------------------------------------------------------
module kmp_substring_matcher (
  input  logic                           clk,
  input  logic                           rst_n,
  kmp_in_if.sink                         in_ch,
  kmp_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [kmp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [kmp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int N  = kmp_pkg::MAX_PATTERN_LENGTH;
  localparam int PW = kmp_pkg::POSITION_WIDTH;

  kmp_pkg::kmp_cfg_t      cfg;
  kmp_pkg::kmp_cell_ctrl_t cell_ctrl;

  logic                          accept;
  logic [N-1:0]                  link;
  logic [N-1:0]                  hit_nxt;
  logic [N-1:0]                  hit_r;

  logic [PW-1:0]                 pos_r, pos_nxt, cur_pos, start_pos;
  logic                          sat_r, sat_nxt;
  logic [kmp_pkg::LEN_W-1:0]     len_m1;
  logic [kmp_pkg::PAT_IDX_W-1:0] last_idx;
  logic                          found;

  logic                              out_valid_r;
  logic                              match_found_r;
  logic [kmp_pkg::MATCH_START_W-1:0] match_start_r;
  logic                              pos_sat_r;

  kmp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The output register frees up whenever its word is taken in this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cell_ctrl.accept = accept;
  assign cell_ctrl.clear  = cfg.wr;

  // The head cell always has an empty prefix behind it. Further down, a new
  // text forgets whatever the previous text left in the chain.
  always_comb begin
    link[0] = 1'b1;
    for (int k = 1; k < N; k++) begin
      link[k] = hit_r[k-1] && !in_ch.new_text;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    kmp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .text_char (in_ch.text_char),
      .pat_byte  (cfg.pattern[8*g +: 8]),
      .link_in   (link[g]),
      .hit_nxt   (hit_nxt[g]),
      .hit_r     (hit_r[g])
    );
  end

  // A full occurrence ends here when the cell for the last pattern byte fires.
  assign len_m1   = cfg.eff_len - kmp_pkg::LEN_W'(1);
  assign last_idx = len_m1[kmp_pkg::PAT_IDX_W-1:0];
  assign found    = hit_nxt[last_idx];

  assign cur_pos   = in_ch.new_text ? '0 : pos_r;
  assign start_pos = cur_pos - PW'(len_m1);

  // The counter stops at all ones and the sticky flag records it.
  always_comb begin
    if (cur_pos == {PW{1'b1}}) begin
      pos_nxt = cur_pos;
      sat_nxt = 1'b1;
    end else begin
      pos_nxt = cur_pos + PW'(1);
      sat_nxt = sat_r && !in_ch.new_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sat_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match_found_r <= found;
      match_start_r <= found ? kmp_pkg::MATCH_START_W'(start_pos) : '0;
      pos_sat_r     <= sat_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.match_found        = match_found_r;
  assign out_ch.match_start        = match_start_r;
  assign out_ch.position_saturated = pos_sat_r;

  // A register write leaves no partial match behind in any cell.
  a_clear_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.wr |=> (hit_r == '0))
    else $error("partial match survived a configuration write");

  // Every accepted word puts a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  // Saturation stays set until a new text begins.
  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sat_r && accept && !in_ch.new_text) |=> sat_r)
    else $error("saturation flag dropped within a text");

endmodule

[bench/kmp_substring_matcher_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_substring_matcher_test
// Self-checking bench for the streaming substring matcher.
// ----------------------------------------------------------------------------
// Text words are pushed through the input channel while a software matcher
// predicts, for every accepted word, the match flag, the start position and
// the saturation flag. The result channel is compared word by word in order.
// Patterns are rewritten between phases over the register port, covering
// the shortest and longest patterns and the clamped out-of-range lengths.
// ----------------------------------------------------------------------------
module kmp_substring_matcher_test;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int NUM_PHASES      = 12;
  localparam int PHASE_ITEMS     = 145;
  localparam int LONG_ITEMS      = 400;
  localparam int STEADY_PHASE    = 6;
  localparam int IDLE_PCT        = 10;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;

  // Register index outside the map; a write there must change nothing.
  localparam logic [kmp_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } text_word_t;

  typedef struct packed {
    logic                              found;
    logic [kmp_pkg::MATCH_START_W-1:0] start;
    logic                              sat;
  } match_word_t;

  // Clock, reset and every input of the block start at known values.
  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           drv_valid   = 1'b0;
  logic [7:0]                     drv_char    = 8'h00;
  logic                           drv_first   = 1'b0;
  logic                           mon_ready   = 1'b0;
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [kmp_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  kmp_in_if  in_if ();
  kmp_out_if out_if ();

  assign in_if.valid     = drv_valid;
  assign in_if.text_char = drv_char;
  assign in_if.new_text  = drv_first;
  assign out_if.ready    = mon_ready;

  kmp_substring_matcher u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Words waiting to be sent and results still owed by the block.
  text_word_t  text_queue[$];
  match_word_t owed_results[$];

  int unsigned drv_idle_pct   = IDLE_PCT;
  int unsigned mon_idle_pct   = IDLE_PCT;
  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned matches_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned cfg_writes     = 0;

  // --------------------------------------------------------------------------
  // Software matcher: its own copy of the registers, the failure table and
  // the scan state. It is advanced once per accepted text word.
  // --------------------------------------------------------------------------
  logic [kmp_pkg::LEN_W-1:0]          sw_len_reg;
  logic [kmp_pkg::PAT_WORD_W-1:0]     sw_words [4];
  int unsigned                        sw_fail [0:kmp_pkg::MAX_PATTERN_LENGTH];
  int unsigned                        sw_prefix;
  logic [kmp_pkg::POSITION_WIDTH-1:0] sw_pos;
  logic                               sw_sat;

  // Lengths outside 1..32 are clamped, so a zero acts as one.
  function automatic int unsigned eff_length(logic [kmp_pkg::LEN_W-1:0] l);
    if (l < 1) return 1;
    if (l > kmp_pkg::MAX_PATTERN_LENGTH) return kmp_pkg::MAX_PATTERN_LENGTH;
    return l;
  endfunction

  function automatic logic [7:0] sw_pat_byte(int unsigned k);
    return sw_words[(k >> 3) & 3][(k & 7) * 8 +: 8];
  endfunction

  // Classic prefix-function build over the bytes in use.
  function automatic void rebuild_failure();
    int unsigned m;
    int unsigned i;
    int unsigned j;
    m = eff_length(sw_len_reg);
    for (i = 0; i <= kmp_pkg::MAX_PATTERN_LENGTH; i++) sw_fail[i] = 0;
    for (i = 1; i < m; i++) begin
      j = sw_fail[i];
      while (j != 0 && sw_pat_byte(i) != sw_pat_byte(j)) j = sw_fail[j];
      sw_fail[i+1] = (sw_pat_byte(i) == sw_pat_byte(j)) ? j + 1 : 0;
    end
  endfunction

  function automatic void reset_matcher();
    int unsigned w;
    sw_len_reg = 1;
    for (w = 0; w < 4; w++) sw_words[w] = '0;
    sw_prefix = 0;
    sw_pos    = '0;
    sw_sat    = 1'b0;
    rebuild_failure();
  endfunction

  // A write to a mapped register rebuilds the table and drops the partial
  // match; position and the sticky flag survive it.
  function automatic void apply_reg_write(logic [kmp_pkg::REG_IDX_W-1:0] idx,
                                          logic [kmp_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      kmp_pkg::REG_PATTERN_LENGTH:  sw_len_reg  = val[kmp_pkg::LEN_W-1:0];
      kmp_pkg::REG_PATTERN_BYTES_0: sw_words[0] = val;
      kmp_pkg::REG_PATTERN_BYTES_1: sw_words[1] = val;
      kmp_pkg::REG_PATTERN_BYTES_2: sw_words[2] = val;
      kmp_pkg::REG_PATTERN_BYTES_3: sw_words[3] = val;
      default: return;
    endcase
    rebuild_failure();
    sw_prefix = 0;
  endfunction

  // Advance the scan by one text byte and return the result it causes.
  function automatic match_word_t scan_byte(text_word_t w);
    match_word_t                        r;
    int unsigned                        m;
    int unsigned                        j;
    logic [kmp_pkg::POSITION_WIDTH-1:0] p;
    m = eff_length(sw_len_reg);
    if (w.first) begin
      sw_prefix = 0;
      sw_pos    = '0;
      sw_sat    = 1'b0;
    end
    p = sw_pos;
    j = sw_prefix;
    if (j >= m) j = 0;
    while (j != 0 && sw_pat_byte(j) != w.ch) j = sw_fail[j];
    if (sw_pat_byte(j) == w.ch) j++;
    r.found = 1'b0;
    r.start = '0;
    if (j == m) begin
      // Full match: report it and fall back so overlaps are still seen.
      r.found = 1'b1;
      r.start = kmp_pkg::MATCH_START_W'(p - kmp_pkg::POSITION_WIDTH'(m - 1));
      j = sw_fail[m];
    end
    sw_prefix = j;
    if (p == {kmp_pkg::POSITION_WIDTH{1'b1}}) sw_sat = 1'b1;
    else sw_pos = p + 1'b1;
    r.sat = sw_sat;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: takes the next word from the queue whenever the channel is free,
  // idling at random. The prediction is made at the edge of acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_text
    text_word_t  nxt;
    match_word_t res;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        res = scan_byte('{ch: drv_char, first: drv_first});
        owed_results = {owed_results, res};
        words_sent++;
      end
      if (!drv_valid || in_if.ready) begin
        if (text_queue.size() > 0 && $urandom_range(99) >= drv_idle_pct) begin
          nxt = text_queue.pop_front();
          drv_valid <= 1'b1;
          drv_char  <= nxt.ch;
          drv_first <= nxt.first;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stalls at random and checks each accepted result word against
  // the oldest prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    match_word_t want;
    if (!rst_n) begin
      mon_ready <= 1'b0;
    end else begin
      if (out_if.valid && mon_ready) begin
        results_seen++;
        if (out_if.match_found) matches_seen++;
        if (owed_results.size() == 0) begin
          $display("%0t: result word with no prediction pending (found=%0b start=%0d)",
                   $time, out_if.match_found, out_if.match_start);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_if.match_found !== want.found) begin
            $display("%0t: match_found expected %0b actual %0b",
                     $time, want.found, out_if.match_found);
            mismatch_count++;
          end
          if (out_if.match_start !== want.start) begin
            $display("%0t: match_start expected %0d actual %0d",
                     $time, want.start, out_if.match_start);
            mismatch_count++;
          end
          if (out_if.position_saturated !== want.sat) begin
            $display("%0t: position_saturated expected %0b actual %0b",
                     $time, want.sat, out_if.position_saturated);
            mismatch_count++;
          end
        end
      end
      mon_ready <= ($urandom_range(99) >= mon_idle_pct);
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, owed_results.size());
      $display("kmp_substring_matcher_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_text(input logic [7:0] ch, input logic first);
    text_word_t w;
    w.ch    = ch;
    w.first = first;
    text_queue = {text_queue, w};
  endtask

  // Register write: setup cycle, then access cycle completed while pready.
  task automatic write_reg(input logic [kmp_pkg::REG_IDX_W-1:0] idx,
                           input logic [kmp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= kmp_pkg::CFG_ADDR_W'({idx, 3'b000});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    apply_reg_write(idx, val);
    cfg_writes++;
  endtask

  // Block until every queued word is sent and every result has come back,
  // then let the result register settle.
  task automatic wait_drained();
    while (text_queue.size() > 0 || drv_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]                alph [3];
    logic [7:0]                pat [kmp_pkg::MAX_PATTERN_LENGTH];
    logic [63:0]               word_val;
    logic [kmp_pkg::LEN_W-1:0] len_val;
    int unsigned               m;
    int unsigned               budget;
    int unsigned               n;
    int unsigned               k;
    int unsigned               r;
    logic                      first;

    reset_matcher();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern is a single zero byte, so every zero byte matches.
    push_text(8'h00, 1'b1);
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(8'h00, 1'b0);
    wait_drained();

    // Pattern "aba": overlapping hits, then a new text mid-stream.
    write_reg(kmp_pkg::REG_PATTERN_BYTES_0, 64'h0000_0000_0061_6261);
    write_reg(kmp_pkg::REG_PATTERN_BYTES_1, 64'h0);
    write_reg(kmp_pkg::REG_PATTERN_BYTES_2, 64'h0);
    write_reg(kmp_pkg::REG_PATTERN_BYTES_3, 64'h0);
    write_reg(kmp_pkg::REG_PATTERN_LENGTH, 64'd3);
    push_text(8'h61, 1'b1);
    push_text(8'h62, 1'b0);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b0);
    push_text(8'h61, 1'b0);
    push_text(8'h61, 1'b1);
    push_text(8'h62, 1'b0);
    push_text(8'h61, 1'b0);
    wait_drained();

    // A write outside the register map must keep the partial match alive.
    write_reg(REG_UNMAPPED, rand64());
    push_text(8'h62, 1'b0);
    push_text(8'h61, 1'b0);
    wait_drained();

    // Length zero acts as one; the position carries on across the write.
    write_reg(kmp_pkg::REG_PATTERN_BYTES_0, 64'h0000_0000_0000_00FF);
    write_reg(kmp_pkg::REG_PATTERN_LENGTH, 64'd0);
    push_text(8'hFF, 1'b0);
    push_text(8'h7F, 1'b0);
    push_text(8'hFF, 1'b1);
    wait_drained();

    // Random phases. Most text is drawn from a three-byte alphabet that most
    // phases also build the pattern from, with whole pattern copies spliced in so
    // that full and overlapping matches are frequent; the rest is arbitrary noise.
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (k = 0; k < 3; k++) alph[k] = 8'($urandom);
      if (p == 0) alph[0] = 8'hFF;
      if (p == 4) alph[0] = 8'h00;

      case (p)
        0:       len_val = kmp_pkg::LEN_W'(kmp_pkg::MAX_PATTERN_LENGTH);
        1:       len_val = {kmp_pkg::LEN_W{1'b1}};
        2:       len_val = '0;
        3:       len_val = 1;
        default: len_val = ($urandom_range(99) < 15)
                           ? kmp_pkg::LEN_W'($urandom)
                           : kmp_pkg::LEN_W'($urandom_range(1, 6));
      endcase

      for (int w = 0; w < 4; w++) begin
        if (p == 0) begin
          word_val = {64{1'b1}};
        end else if (p == 4) begin
          word_val = '0;
        end else if (p % 4 == 1) begin
          word_val = rand64();
        end else begin
          for (k = 0; k < 8; k++) word_val[k*8 +: 8] = alph[$urandom_range(2)];
        end
        for (k = 0; k < 8; k++) pat[w*8 + k] = word_val[k*8 +: 8];
        case (w)
          0:       write_reg(kmp_pkg::REG_PATTERN_BYTES_0, word_val);
          1:       write_reg(kmp_pkg::REG_PATTERN_BYTES_1, word_val);
          2:       write_reg(kmp_pkg::REG_PATTERN_BYTES_2, word_val);
          default: write_reg(kmp_pkg::REG_PATTERN_BYTES_3, word_val);
        endcase
      end
      write_reg(kmp_pkg::REG_PATTERN_LENGTH, kmp_pkg::CFG_DATA_W'(len_val));

      // One phase runs long with neither side ever idling.
      drv_idle_pct = (p == STEADY_PHASE) ? 0 : IDLE_PCT;
      mon_idle_pct = (p == STEADY_PHASE) ? 0 : IDLE_PCT;
      budget = (p == STEADY_PHASE) ? LONG_ITEMS : PHASE_ITEMS;

      m = eff_length(len_val);
      n = 0;
      while (n < budget) begin
        // Each phase starts a new text on a coin toss, else continues the previous text across the rewrite.
        first = (n == 0 && $urandom_range(1)) || ($urandom_range(99) < 2);
        r = $urandom_range(99);
        if (r < 20) begin
          for (k = 0; k < m; k++) push_text(pat[k], first && k == 0);
          n += m;
        end else if (r < 30) begin
          push_text(8'($urandom), first);
          n++;
        end else begin
          push_text(alph[$urandom_range(2)], first);
          n++;
        end
      end
      wait_drained();
    end

    drv_idle_pct = IDLE_PCT;
    mon_idle_pct = IDLE_PCT;
    wait_drained();

    $display("Covered %0d text words, %0d results, %0d matches, %0d register writes.",
             words_sent, results_seen, matches_seen, cfg_writes);
    $display("Patterns of length 1 to 32, clamped lengths, overlaps, new texts; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("kmp_substring_matcher_test OK");
    end else begin
      $display("kmp_substring_matcher_test NOT OK");
    end
    $finish;
  end

endmodule
